// ===== hdl/lcdseq_pkg.sv =====
package lcdseq_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_CHAR  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_MOVE  = 2'd3
   } op_kind_type;

   // one classified word as it sits in the queue
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  char_byte;
      logic        last_char;
      logic [7:0]  position;
   } item_type;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BUSY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [7:0] CMD_FUNCTION_SET = 8'd56;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'd15;
   localparam logic [7:0] CMD_CLEAR        = 8'd1;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'd6;

   localparam logic [7:0] STARTUP_WAIT_RESET = 8'd20;

   localparam logic [1:0] INIT_LAST_STEP = 2'd3;

   function automatic logic [7:0] init_command(input logic [1:0] step);
      logic [7:0] cmd;
      unique case (step)
         2'd0:    cmd = CMD_FUNCTION_SET;
         2'd1:    cmd = CMD_DISPLAY_ON;
         2'd2:    cmd = CMD_CLEAR;
         default: cmd = CMD_ENTRY_MODE;
      endcase
      return cmd;
   endfunction

endpackage

// ===== hdl/lcdseq_ram.sv =====
module lcdseq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lcdseq_front.sv =====
module lcdseq_front
   import lcdseq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_char_byte,
   input  logic       req_last_char,
   input  logic [7:0] req_line_base,
   input  logic [7:0] req_column,
   output logic       q_valid,
   output item_type   q_head,
   input  logic       q_pop
);

   item_type   entries_ff [2];
   item_type   item_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   // classify and fold the position sum in before queueing
   always_comb begin
      item_in.kind      = op_kind_type'(req_cmd);
      item_in.char_byte = req_char_byte;
      item_in.last_char = req_last_char;
      item_in.position  = req_line_base + req_column;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ===== hdl/lcdseq_back.sv =====
module lcdseq_back
   import lcdseq_pkg::*;
#(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] startup_wait,
   input  logic       q_valid,
   input  item_type   q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_lcd_rs,
   output logic       rsp_lcd_rw,
   output logic       rsp_lcd_en,
   output logic [7:0] rsp_lcd_data,
   output logic       rsp_write_done,
   output logic       rsp_clear_done,
   output logic       rsp_move_done,
   output logic       rsp_ready_res
);

   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int AW = BUFFER_DEPTH > 1 ? $clog2(BUFFER_DEPTH) : 1;

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_WRITE,
      MODE_CLEAR,
      MODE_MOVE
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [1:0] init_step_ff, init_step_in;
   logic [7:0] wait_count_ff, wait_count_in;
   logic       init_complete_ff, init_complete_in;
   logic [CW-1:0] load_count_ff, load_count_in;
   logic [CW-1:0] string_length_ff, string_length_in;
   logic [CW-1:0] char_index_ff, char_index_in;
   logic [7:0] position_ff, position_in;
   logic       rs_ff, rs_in;
   logic       en_ff, en_in;
   logic [7:0] data_ff, data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic       wdone_ff, wdone_in;
   logic       cdone_ff, cdone_in;
   logic       mdone_ff, mdone_in;
   logic       byp_valid_ff, byp_valid_in;
   logic [7:0] byp_data_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;
   logic [7:0]    char_data;

   assign q_pop = q_valid && (!rsp_valid_ff || !rsp_stall);

   // the buffer is read ahead at the next index; a write to that same
   // entry in the same cycle is forwarded round the RAM
   assign char_data = byp_valid_ff ? byp_data_ff : ram_rdata;
   assign ram_waddr = load_count_ff[AW-1:0];
   assign ram_raddr = char_index_in[AW-1:0];

   lcdseq_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_char_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (q_head.char_byte),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      mode_in          = mode_ff;
      init_step_in     = init_step_ff;
      wait_count_in    = wait_count_ff;
      init_complete_in = init_complete_ff;
      load_count_in    = load_count_ff;
      string_length_in = string_length_ff;
      char_index_in    = char_index_ff;
      position_in      = position_ff;
      rs_in            = rs_ff;
      en_in            = en_ff;
      data_in          = data_ff;
      status_in        = status_ff;
      wdone_in         = wdone_ff;
      cdone_in         = cdone_ff;
      mdone_in         = mdone_ff;
      ram_we           = 1'b0;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      if (q_pop) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         wdone_in     = 1'b0;
         cdone_in     = 1'b0;
         mdone_in     = 1'b0;

         if (q_head.kind == OP_TICK) begin
            if (!init_complete_ff) begin
               if (wait_count_ff < startup_wait) begin
                  wait_count_in = wait_count_ff + 8'd1;
               end else if (en_ff) begin
                  en_in = 1'b0;
                  if (init_step_ff == INIT_LAST_STEP) begin
                     init_complete_in = 1'b1;
                  end else begin
                     init_step_in = init_step_ff + 2'd1;
                  end
               end else begin
                  data_in = init_command(init_step_ff);
                  rs_in   = 1'b0;
                  en_in   = 1'b1;
               end
            end else begin
               unique case (mode_ff)
                  MODE_WRITE: begin
                     if (en_ff) begin
                        en_in = 1'b0;
                     end else if (char_index_ff >= string_length_ff) begin
                        mode_in       = MODE_IDLE;
                        char_index_in = '0;
                        wdone_in      = 1'b1;
                     end else begin
                        data_in       = char_data;
                        rs_in         = 1'b1;
                        en_in         = 1'b1;
                        char_index_in = char_index_ff + CW'(1);
                     end
                  end
                  MODE_CLEAR: begin
                     if (en_ff) begin
                        en_in    = 1'b0;
                        mode_in  = MODE_IDLE;
                        cdone_in = 1'b1;
                     end else begin
                        data_in = CMD_CLEAR;
                        rs_in   = 1'b0;
                        en_in   = 1'b1;
                     end
                  end
                  MODE_MOVE: begin
                     if (en_ff) begin
                        en_in    = 1'b0;
                        mode_in  = MODE_IDLE;
                        mdone_in = 1'b1;
                     end else begin
                        data_in = position_ff;
                        rs_in   = 1'b0;
                        en_in   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end else if (mode_ff != MODE_IDLE) begin
            status_in = ST_BUSY;
         end else begin
            unique case (q_head.kind)
               OP_CHAR: begin
                  if (load_count_ff < CW'(BUFFER_DEPTH)) begin
                     ram_we        = 1'b1;
                     load_count_in = load_count_ff + CW'(1);
                  end else begin
                     status_in = ST_FULL;
                  end
                  if (q_head.last_char) begin
                     string_length_in = load_count_in;
                     load_count_in    = '0;
                     char_index_in    = '0;
                     mode_in          = MODE_WRITE;
                  end
               end
               OP_CLEAR: begin
                  mode_in = MODE_CLEAR;
               end
               OP_MOVE: begin
                  position_in = q_head.position;
                  mode_in     = MODE_MOVE;
               end
               default: begin
               end
            endcase
         end
      end

      byp_valid_in = ram_we && (ram_waddr == char_index_in[AW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_IDLE;
         init_step_ff     <= 2'd0;
         wait_count_ff    <= 8'd0;
         init_complete_ff <= 1'b0;
         load_count_ff    <= '0;
         string_length_ff <= '0;
         char_index_ff    <= '0;
         position_ff      <= 8'd0;
         rs_ff            <= 1'b0;
         en_ff            <= 1'b0;
         data_ff          <= 8'd0;
         rsp_valid_ff     <= 1'b0;
         status_ff        <= ST_OK;
         wdone_ff         <= 1'b0;
         cdone_ff         <= 1'b0;
         mdone_ff         <= 1'b0;
         byp_valid_ff     <= 1'b0;
      end else begin
         mode_ff          <= mode_in;
         init_step_ff     <= init_step_in;
         wait_count_ff    <= wait_count_in;
         init_complete_ff <= init_complete_in;
         load_count_ff    <= load_count_in;
         string_length_ff <= string_length_in;
         char_index_ff    <= char_index_in;
         position_ff      <= position_in;
         rs_ff            <= rs_in;
         en_ff            <= en_in;
         data_ff          <= data_in;
         rsp_valid_ff     <= rsp_valid_in;
         status_ff        <= status_in;
         wdone_ff         <= wdone_in;
         cdone_ff         <= cdone_in;
         mdone_ff         <= mdone_in;
         byp_valid_ff     <= byp_valid_in;
      end
      byp_data_ff <= q_head.char_byte;
   end

   // pin state only moves when a word is taken, so it doubles as the result
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_lcd_rs     = rs_ff;
   assign rsp_lcd_rw     = 1'b0;
   assign rsp_lcd_en     = en_ff;
   assign rsp_lcd_data   = data_ff;
   assign rsp_write_done = wdone_ff;
   assign rsp_clear_done = cdone_ff;
   assign rsp_move_done  = mdone_ff;
   assign rsp_ready_res  = init_complete_ff;

endmodule

// ===== hdl/char_lcd_8bit_sequencer.sv =====
// Character LCD sequencer for an 8-bit HD44780-style bus. Every word on the
// req_ channel (a tick, a character, a clear or a set-position request) gives
// exactly one rsp_ word carrying the status, the LCD pin levels after that
// word and the done pulses. One word is taken per clock cycle while no stall
// holds it (req_stall when the queue is full, or rsp_stall); its result passes
// through the queue and then the sequencer's result register. Throughput is
// set by the back sequencer, which updates its state once per word, and by the
// character buffer, a RAM with registered read that is fetched ahead
// at the next index. A two-word queue sits between the classifying front end
// and the sequencer so each side stalls independently. startup_wait is written
// through the csr_ port, which is always ready; write it only while idle.
module char_lcd_8bit_sequencer
   import lcdseq_pkg::*;
#(
   parameter int BUFFER_DEPTH = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [7:0] req_char_byte,
   input  logic       req_last_char,
   input  logic [7:0] req_line_base,
   input  logic [7:0] req_column,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic       rsp_lcd_rs,
   output logic       rsp_lcd_rw,
   output logic       rsp_lcd_en,
   output logic [7:0] rsp_lcd_data,
   output logic       rsp_write_done,
   output logic       rsp_clear_done,
   output logic       rsp_move_done,
   output logic       rsp_ready_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic [7:0] startup_wait_q_ff;
   logic       q_valid;
   item_type   q_head;
   logic       q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         startup_wait_q_ff <= STARTUP_WAIT_RESET;
      end else if (csr_valid && csr_ready) begin
         startup_wait_q_ff <= csr_data;
      end
   end

   lcdseq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_cmd       (req_cmd),
      .req_char_byte (req_char_byte),
      .req_last_char (req_last_char),
      .req_line_base (req_line_base),
      .req_column    (req_column),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop)
   );

   lcdseq_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .startup_wait   (startup_wait_q_ff),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_lcd_rs     (rsp_lcd_rs),
      .rsp_lcd_rw     (rsp_lcd_rw),
      .rsp_lcd_en     (rsp_lcd_en),
      .rsp_lcd_data   (rsp_lcd_data),
      .rsp_write_done (rsp_write_done),
      .rsp_clear_done (rsp_clear_done),
      .rsp_move_done  (rsp_move_done),
      .rsp_ready_res  (rsp_ready_res)
   );

endmodule

// ===== hdl/lcdseq_checker.sv =====
module lcdseq_checker
   import lcdseq_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_status,
   input logic       rsp_lcd_en,
   input logic [7:0] rsp_lcd_data,
   input logic       rsp_write_done,
   input logic       rsp_clear_done,
   input logic       rsp_move_done,
   input logic       rsp_ready_res
);

   // a held word keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_lcd_data) && $stable(rsp_lcd_en))
      else $error("rsp word changed while stalled");

   // init never undoes itself
   a_ready_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_ready_res |=> rsp_ready_res)
      else $error("ready_res dropped after init");

   // a job finishes only on an ok tick with EN low, after init
   a_done_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_write_done || rsp_clear_done || rsp_move_done)
         |-> !rsp_lcd_en && rsp_status == ST_OK && rsp_ready_res)
      else $error("done pulse with EN high, bad status or before init");

   a_done_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_write_done, rsp_clear_done, rsp_move_done}))
      else $error("more than one done pulse");

endmodule

bind char_lcd_8bit_sequencer lcdseq_checker u_checker (.*);
